[sv/sidl_pkg.sv]
// ----------------------------------------------------------------------------
// sidl_pkg
// shared types and constants for the sorted id table lookup unit
// ----------------------------------------------------------------------------
package sidl_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 4096;
  localparam int ID_BITS     = 48;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // fixed field widths of the item ports
  localparam int WAY_ID_W    = 48;
  localparam int ENTRY_IDX_W = 12;
  localparam int POS_W       = 12;
  localparam int COUNT_W     = 13;

  // compare width: key at full port width against the stored id
  localparam int CMP_W = (ID_BITS > WAY_ID_W) ? ID_BITS : WAY_ID_W;

  // register port
  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic [0:0] REG_WAY_COUNT = 1'b0;

  // item function codes
  typedef enum logic [0:0] {
    FUNC_LOAD   = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_e;

  // one table entry
  typedef struct packed {
    logic               flag;
    logic [ID_BITS-1:0] id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[sv/sidl_ram.sv]
// ----------------------------------------------------------------------------
// sidl_ram
// generic ram, one write port and two read ports with registered read data
// ----------------------------------------------------------------------------
module sidl_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 49,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

[sv/sorted_id_table_lookup_unit.sv]
// ----------------------------------------------------------------------------
// sorted_id_table_lookup_unit
// sorted id table with a halving search, one probe pair per ram read
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  --------  ---------  ---------------------------  --------------------------
//  item in   in         start high and busy low      func, entry_index,
//                                                    way_id, entry_flag
//  result    out        done_o strobe, one cycle     found, position, flagged
//  config    in/out     apb, write at psel&penable   way_count at address 0
//
//  a load item writes one entry at its accept edge and takes one cycle, so
//  loads can follow each other without a gap
//  a lookup takes 2 + s cycles from accept to the result strobe, s being the
//  number of halving steps (about log2 of way_count, 12 or so for a full
//  table): one cycle reads the end entries, each step reads the probe entry
//  and the lowered upper entry on the two ram read ports, and the ram read
//  latency sets one cycle per step
//  with way_count at 0 the not-found result shows in the cycle after accept
//  reset clears the control state and way_count, the table is not cleared
//  the receiver cannot stall, the result strobe lasts one cycle and busy is
//  already low in that cycle, so the next item may be taken with it
//
module sorted_id_table_lookup_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item in
  input  logic                              start,
  output logic                              busy,
  input  logic                              func_i,
  input  logic [sidl_pkg::ENTRY_IDX_W-1:0]  entry_index_i,
  input  logic [sidl_pkg::WAY_ID_W-1:0]     way_id_i,
  input  logic                              entry_flag_i,
  // result
  output logic                              done_o,
  output logic                              found_o,
  output logic [sidl_pkg::POS_W-1:0]        position_o,
  output logic                              flagged_o,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sidl_pkg::PADDR_W-1:0]      paddr,
  input  logic [sidl_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sidl_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  import sidl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_STEP
  } state_e;

  state_e               state_q;
  logic [COUNT_W-1:0]   way_count_q;

  // search window and halving distance
  logic [ADDR_W-1:0]    lo_q, hi_q, d_q;
  logic [WAY_ID_W-1:0]  key_q;

  // registered result
  logic                 done_q, found_q, flagged_q;
  logic [POS_W-1:0]     position_q;

  // ram side
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, raddr_a, raddr_b;
  logic [ENTRY_W-1:0]   ram_wdata, rdata_a, rdata_b;
  entry_t               rd_a, rd_b, wr_ent;

  // item decode
  logic                 accept, acc_load, acc_lookup;
  logic [ADDR_W:0]      n_eff;
  logic [ADDR_W-1:0]    hi_init;

  // search datapath
  logic [CMP_W-1:0]     key_c, id_a_c, id_b_c;
  logic                 less;
  logic [ADDR_W-1:0]    nd_f, lo_g, hi_l, nd_g, nd_l;
  logic [ADDR_W-1:0]    nxt_lo, nxt_hi, nxt_d;
  logic                 fin, fin_found, fin_flag;
  logic [ADDR_W-1:0]    fin_pos;

  assign accept     = start && !busy;
  assign acc_load   = accept && (func_i == FUNC_LOAD);
  assign acc_lookup = accept && (func_i == FUNC_LOOKUP);

  // way_count above the depth is clipped to the depth
  assign n_eff   = (32'(way_count_q) > TABLE_DEPTH) ? (ADDR_W + 1)'(TABLE_DEPTH)
                                                    : (ADDR_W + 1)'(way_count_q);
  assign hi_init = ADDR_W'(n_eff - (ADDR_W + 1)'(1));

  // load path, indexes beyond the table are dropped
  assign wr_ent.flag = entry_flag_i;
  assign wr_ent.id   = ID_BITS'(way_id_i);
  assign ram_wdata   = wr_ent;
  assign ram_waddr   = ADDR_W'(entry_index_i);
  assign ram_we      = acc_load && (32'(entry_index_i) < TABLE_DEPTH);

  // loads and lookups never overlap, so a lookup read always sees earlier loads
  sidl_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  assign rd_a = entry_t'(rdata_a);
  assign rd_b = entry_t'(rdata_b);

  assign key_c  = CMP_W'(key_q);
  assign id_a_c = CMP_W'(rd_a.id);
  assign id_b_c = CMP_W'(rd_b.id);

  // port a carries the low entry (first pass) or the probe at lo+d,
  // port b the high entry (first pass) or the entry at hi-d
  assign less = key_c < id_a_c;

  // both branch outcomes are index-only, worked out beside the compare
  assign nd_f = (hi_q - lo_q) >> 1;
  assign lo_g = lo_q + d_q;
  assign hi_l = hi_q - d_q;
  assign nd_g = (hi_q - lo_g) >> 1;
  assign nd_l = (hi_l - lo_q) >> 1;

  always_comb begin
    nxt_lo    = lo_q;
    nxt_hi    = hi_q;
    nxt_d     = nd_f;
    fin       = 1'b0;
    fin_found = 1'b0;
    fin_pos   = '0;
    fin_flag  = 1'b0;
    raddr_a   = '0;
    raddr_b   = hi_init;
    case (state_q)
      ST_FIRST: begin
        // end entries: range check, then hi, then lo
        if (key_c > id_b_c || key_c < id_a_c) begin
          fin = 1'b1;
        end else if (key_c == id_b_c) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_pos   = hi_q;
          fin_flag  = rd_b.flag;
        end else if (key_c == id_a_c) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_pos   = lo_q;
          fin_flag  = rd_a.flag;
        end else if (nd_f == '0) begin
          fin = 1'b1;
        end
        raddr_a = lo_q + nd_f;
        raddr_b = hi_q - nd_f;
      end
      ST_STEP: begin
        // only the moved end is new, the other one already missed
        if (less) begin
          nxt_hi  = hi_l;
          nxt_d   = nd_l;
          raddr_a = lo_q + nd_l;
          raddr_b = hi_l - nd_l;
          if (key_c == id_b_c) begin
            fin       = 1'b1;
            fin_found = 1'b1;
            fin_pos   = hi_l;
            fin_flag  = rd_b.flag;
          end else if (nd_l == '0) begin
            fin = 1'b1;
          end
        end else begin
          nxt_lo  = lo_g;
          nxt_d   = nd_g;
          raddr_a = lo_g + nd_g;
          raddr_b = hi_q - nd_g;
          if (key_c == id_a_c) begin
            fin       = 1'b1;
            fin_found = 1'b1;
            fin_pos   = lo_g;
            fin_flag  = rd_a.flag;
          end else if (nd_g == '0) begin
            fin = 1'b1;
          end
        end
      end
      default: begin
        // idle: present the end entries for a lookup accepted now
        raddr_a = '0;
        raddr_b = hi_init;
      end
    endcase
  end

  // search sequencer and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      lo_q       <= '0;
      hi_q       <= '0;
      d_q        <= '0;
      key_q      <= '0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      position_q <= '0;
      flagged_q  <= 1'b0;
    end else begin
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      position_q <= '0;
      flagged_q  <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (acc_lookup) begin
            key_q <= way_id_i;
            lo_q  <= '0;
            hi_q  <= hi_init;
            if (n_eff == '0) begin
              // empty table
              done_q <= 1'b1;
            end else begin
              state_q <= ST_FIRST;
            end
          end
        end
        ST_FIRST, ST_STEP: begin
          lo_q <= nxt_lo;
          hi_q <= nxt_hi;
          d_q  <= nxt_d;
          if (fin) begin
            state_q    <= ST_IDLE;
            done_q     <= 1'b1;
            found_q    <= fin_found;
            position_q <= POS_W'(fin_pos);
            flagged_q  <= fin_flag;
          end else begin
            state_q <= ST_STEP;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy       = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign found_o    = found_q;
  assign position_o = position_q;
  assign flagged_o  = flagged_q;

  // register port, word index taken from paddr above the byte bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_count_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[PADDR_W-1:2] == REG_WAY_COUNT) begin
        way_count_q <= COUNT_W'(pwdata);
      end
    end
  end

  assign prdata = (paddr[PADDR_W-1:2] == REG_WAY_COUNT) ? APB_DATA_W'(way_count_q) : '0;
  assign pready = 1'b1;

endmodule

[sv/sidl_checker.sv]
// ----------------------------------------------------------------------------
// sidl_checker
// port level checks of the sorted id table lookup unit
// ----------------------------------------------------------------------------
module sidl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             func_i,
  input logic                             done_o,
  input logic                             found_o,
  input logic [sidl_pkg::POS_W-1:0]       position_o,
  input logic                             flagged_o
);

  import sidl_pkg::*;

  // a load item never causes a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_LOAD) |=> !done_o)
    else $error("result after load item");

  // a lookup either finishes at once or holds the unit busy
  a_lookup_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_LOOKUP) |=> (done_o != busy))
    else $error("lookup neither answered nor busy");

  // the unit only goes idle by delivering its result
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without result");

  // result strobe only while idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");

  // a miss carries zero position and flag
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (position_o == '0 && !flagged_o))
    else $error("miss with nonzero payload");

endmodule

bind sorted_id_table_lookup_unit sidl_checker u_sidl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .func_i     (func_i),
  .done_o     (done_o),
  .found_o    (found_o),
  .position_o (position_o),
  .flagged_o  (flagged_o)
);
